[sv/esp_pkg.sv]
// Shared types and constants for the EBML element stream parser.
// No dependencies; imported by the result queue and the core.
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

   localparam logic [1:0] KIND_LEAF    = 2'd0;
   localparam logic [1:0] KIND_SEGMENT = 2'd1;
   localparam logic [1:0] KIND_NOT_EBML = 2'd2;
   localparam logic [1:0] KIND_NO_SEG  = 2'd3;

   localparam logic [31:0] ID_EBML    = 32'h1A45DFA3;
   localparam logic [31:0] ID_SEGMENT = 32'h18538067;

   typedef logic [31:0] master_list_type [8];
   localparam master_list_type MASTER_IDS = '{
      32'h1549A966, 32'h1654AE6B, 32'h1941A469, 32'h000000AE,
      32'h000000E0, 32'h000000E1, 32'h000055B0, 32'h000061A7
   };

   typedef enum logic [3:0] {
      PH_ID      = 4'b0001,
      PH_SIZE    = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      STG_HDR_ID   = 3'b001,
      STG_HDR_BODY = 3'b010,
      STG_SEARCH   = 3'b100
   } stage_type;

   // one result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] element_id;
      logic [55:0] element_size;
      logic [47:0] payload_offset;
      logic [63:0] leaf_value;
      logic [2:0]  nest_level;
      logic        last_of_run;
   } res_type;

   // push request from the parser into the result queue
   typedef struct packed {
      logic [1:0] cnt;
      res_type    r0;
      res_type    r1;
   } push_type;

   function automatic logic is_master(input logic [31:0] id);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (MASTER_IDS[i] == id) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

[sv/esp_rsp_queue.sv]
// Two-entry result queue between the parser and the rsp channel.
// Depends on esp_pkg for res_type and push_type.
`timescale 1ns / 1ps
`default_nettype none

module esp_rsp_queue import esp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          ready,
   output logic          head_valid,
   output res_type       head
);

   res_type    slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;

   // new words are taken only when the queue is empty or its last word is popped this cycle
   assign ready      = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push.cnt != 2'd0) begin
         slot0_in = push.r0;
         slot1_in = push.r1;
         count_in = push.cnt;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

[sv/ebml_element_stream_parser_core.sv]
// EBML element stream parser core: header decode, nesting stack, result queue.
// Depends on esp_pkg and esp_rsp_queue.
//
// Takes one file byte per req word and decodes EBML element headers (ID of
// 1..4 bytes, size of 1..8 bytes). The EBML header must come first; elements
// are then skipped until the Segment. Inside the Segment, known Matroska
// masters are tracked on an end-position stack of MAX_NEST entries; every
// other element is a leaf and yields one rsp word when its last payload byte
// arrives, or its last size byte if it is empty. The whole decode, including
// the parallel compare of all open end positions against the byte position,
// sits between the state registers and a two-entry result queue. A byte that
// causes two results holds req_stall while the queue drains; bytes that cause
// zero or one result flow at one per cycle as long as rsp is not stalled. The
// byte with req_end_of_file high closes the file and the next byte starts a
// new one. Positions wrap modulo 2^POSITION_BITS.
`timescale 1ns / 1ps
`default_nettype none

module ebml_element_stream_parser_core import esp_pkg::*; #(
   parameter int MAX_NEST      = 6,
   parameter int POSITION_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_file,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_element_id,
   output logic [55:0]      rsp_element_size,
   output logic [47:0]      rsp_payload_offset,
   output logic [63:0]      rsp_leaf_value,
   output logic [2:0]       rsp_nest_level,
   output logic             rsp_last_of_run
);

   localparam int LVL_W = $clog2(MAX_NEST + 1);
   localparam int IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
   localparam int PB    = POSITION_BITS;

   // parser state
   phase_type        phase_ff, phase_in;
   stage_type        stage_ff, stage_in;
   logic [31:0]      id_ff, id_in;
   logic [55:0]      size_ff, size_in;
   logic [2:0]       left_ff, left_in;
   logic [63:0]      value_ff, value_in;
   logic [55:0]      pleft_ff, pleft_in;
   logic [PB-1:0]    pos_ff, pos_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             leaf_ff, leaf_in;
   logic [PB-1:0]    eoff_ff, eoff_in;
   logic [LVL_W-1:0] elvl_ff, elvl_in;
   logic [PB-1:0]    soff_ff, soff_in;
   logic [55:0]      ssize_ff, ssize_in;
   logic             sopen_ff, sopen_in;
   logic [PB-1:0]    end_ff [MAX_NEST];

   // stack write port
   logic             push_en;
   logic [IDX_W-1:0] push_idx;
   logic [PB-1:0]    push_val;

   logic     accept, pop, q_ready, q_valid;
   res_type  q_head;
   push_type push;

   // result sources, in emission order
   logic     a_en, cl_en, eof_en;
   res_type  a_res, cl_res, eof_res;

   logic [PB-1:0]    pos_n;
   logic [63:0]      pos_wide, eoff_wide, soff_wide;
   logic [7:0]       b;
   logic             do_close, hd_done, sp_en, sp_leaf;
   logic [PB-1:0]    end_new;
   logic             reach_new;
   logic [MAX_NEST-1:0] reach;
   logic [LVL_W-1:0] lvl_eff, keep;

   assign b      = req_data_byte;
   assign pop    = q_valid && !rsp_stall;
   assign accept = req_valid && q_ready;
   assign req_stall = !q_ready;

   assign pos_n    = pos_ff + PB'(1);
   assign pos_wide = 64'(pos_n);

   always_comb begin
      phase_in = phase_ff;  stage_in = stage_ff;
      id_in    = id_ff;     size_in  = size_ff;   left_in = left_ff;
      value_in = value_ff;  pleft_in = pleft_ff;  pos_in  = pos_n;
      level_in = level_ff;  leaf_in  = leaf_ff;
      eoff_in  = eoff_ff;   elvl_in  = elvl_ff;
      soff_in  = soff_ff;   ssize_in = ssize_ff;  sopen_in = sopen_ff;
      push_en  = 1'b0;
      push_idx = level_ff[IDX_W-1:0];
      end_new  = '0;
      push_val = '0;
      reach_new = 1'b0;
      do_close = 1'b0;
      hd_done  = 1'b0;
      sp_en    = 1'b0;
      sp_leaf  = 1'b0;
      a_en     = 1'b0;
      a_res    = '0;
      cl_en    = 1'b0;
      cl_res   = '0;
      eof_en   = 1'b0;
      eof_res  = '0;
      reach    = '0;
      lvl_eff  = level_ff;
      keep     = '0;
      eoff_wide = '0;
      soff_wide = '0;

      case (phase_ff)
         PH_ID: begin
            if (left_ff == 3'd0) begin
               id_in = {24'd0, b};
               if (b[7])      left_in = 3'd0;
               else if (b[6]) left_in = 3'd1;
               else if (b[5]) left_in = 3'd2;
               else if (b[4]) left_in = 3'd3;
               else begin
                  id_in = '0; left_in = 3'd0;  // invalid first byte
               end
            end else begin
               id_in   = {id_ff[23:0], b};
               left_in = left_ff - 3'd1;
            end
            if (left_in == 3'd0) begin
               if (stage_ff == STG_HDR_ID && id_in != ID_EBML) begin
                  a_en  = 1'b1;
                  a_res.kind = KIND_NOT_EBML;
                  a_res.element_id = id_in;
                  phase_in = PH_DONE;
               end else begin
                  if (stage_ff == STG_HDR_ID) stage_in = STG_HDR_BODY;
                  phase_in = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            if (left_ff == 3'd0) begin
               if (b[7])      begin left_in = 3'd0; size_in = 56'(b & 8'h7F); end
               else if (b[6]) begin left_in = 3'd1; size_in = 56'(b & 8'h3F); end
               else if (b[5]) begin left_in = 3'd2; size_in = 56'(b & 8'h1F); end
               else if (b[4]) begin left_in = 3'd3; size_in = 56'(b & 8'h0F); end
               else if (b[3]) begin left_in = 3'd4; size_in = 56'(b & 8'h07); end
               else if (b[2]) begin left_in = 3'd5; size_in = 56'(b & 8'h03); end
               else if (b[1]) begin left_in = 3'd6; size_in = 56'(b & 8'h01); end
               else if (b[0]) begin left_in = 3'd7; size_in = '0; end
               else           begin left_in = 3'd0; size_in = '0; end
            end else begin
               size_in = {size_ff[47:0], b};
               left_in = left_ff - 3'd1;
            end
            hd_done = (left_in == 3'd0);
         end
         PH_PAYLOAD: begin
            if (leaf_ff && size_ff <= 56'd8) value_in = {value_ff[55:0], b};
            pleft_in = pleft_ff - 56'd1;
            if (pleft_in == 56'd0) begin
               if (leaf_ff) begin
                  eoff_wide = 64'(eoff_ff);
                  a_en = 1'b1;
                  a_res.kind = KIND_LEAF;
                  a_res.element_id = id_ff;
                  a_res.element_size = size_ff;
                  a_res.payload_offset = eoff_wide[47:0];
                  a_res.leaf_value = (size_ff <= 56'd8) ? value_in : 64'd0;
                  a_res.nest_level = 3'(elvl_ff);
               end
               do_close = 1'b1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // element header complete
      end_new   = pos_n + PB'(size_in);
      reach_new = (pos_n >= end_new);
      if (hd_done) begin
         eoff_in = pos_n;
         elvl_in = level_ff;
         if (stage_ff == STG_HDR_BODY) begin
            stage_in = STG_SEARCH;
            sp_en = 1'b1;
         end else if (level_ff == '0) begin
            if (id_in == ID_SEGMENT) begin
               soff_in  = pos_n;
               ssize_in = size_in;
               sopen_in = (size_in == 56'd0);
               push_en  = 1'b1;
               push_val = end_new;
               level_in = LVL_W'(1);
               do_close = 1'b1;
            end else begin
               sp_en = 1'b1;
            end
         end else if (is_master(id_in) && level_ff < LVL_W'(MAX_NEST)) begin
            if (size_in != 56'd0) begin
               push_en  = 1'b1;
               push_val = end_new;
               level_in = level_ff + LVL_W'(1);
            end
            do_close = 1'b1;
         end else begin
            sp_en = 1'b1;
            sp_leaf = 1'b1;
         end
      end

      // payload start
      if (sp_en) begin
         leaf_in  = sp_leaf;
         value_in = '0;
         if (size_in == 56'd0) begin
            if (sp_leaf) begin
               a_en = 1'b1;
               a_res.kind = KIND_LEAF;
               a_res.element_id = id_in;
               a_res.payload_offset = pos_wide[47:0];
               a_res.nest_level = 3'(level_ff);
            end
            do_close = 1'b1;
         end else begin
            pleft_in = size_in;
            phase_in = PH_PAYLOAD;
         end
      end

      // pop the masters whose end is reached, down to the deepest one still open, all levels in parallel
      if (do_close) begin
         phase_in = PH_ID;
         lvl_eff  = level_in;
         for (int i = 0; i < MAX_NEST; i++) begin
            if (i == 0 && sopen_in)
               reach[i] = 1'b0;
            else if (push_en && LVL_W'(i) == level_ff)
               reach[i] = reach_new;
            else
               reach[i] = (pos_n >= end_ff[i]);
         end
         for (int i = 0; i < MAX_NEST; i++) begin
            if (LVL_W'(i) < lvl_eff && !reach[i]) keep = LVL_W'(i + 1);
         end
         level_in = keep;
         if (lvl_eff != '0 && keep == '0) begin
            soff_wide = 64'(soff_in);
            cl_en = 1'b1;
            cl_res.kind = KIND_SEGMENT;
            cl_res.element_id = ID_SEGMENT;
            cl_res.element_size = ssize_in;
            cl_res.payload_offset = soff_wide[47:0];
            phase_in = PH_DONE;
         end
      end

      // end of file closes the run and returns to reset
      if (req_end_of_file) begin
         if (phase_in != PH_DONE) begin
            eof_en = 1'b1;
            if (stage_in == STG_HDR_ID) begin
               eof_res.kind = KIND_NOT_EBML;
            end else if (level_in != '0) begin
               soff_wide = 64'(soff_in);
               eof_res.kind = KIND_SEGMENT;
               eof_res.element_id = ID_SEGMENT;
               eof_res.element_size = ssize_in;
               eof_res.payload_offset = soff_wide[47:0];
            end else begin
               eof_res.kind = KIND_NO_SEG;
            end
         end
         phase_in = PH_ID;  stage_in = STG_HDR_ID;
         id_in = '0;  size_in = '0;  left_in = '0;  value_in = '0;
         pleft_in = '0;  pos_in = '0;  level_in = '0;  leaf_in = 1'b0;
         eoff_in = '0;  elvl_in = '0;  soff_in = '0;  ssize_in = '0;
         sopen_in = 1'b0;
      end
   end

   // pack up to two results in order
   always_comb begin
      push.cnt = 2'(a_en) + 2'(cl_en) + 2'(eof_en);
      push.r0  = a_en ? a_res : (cl_en ? cl_res : eof_res);
      push.r1  = (a_en && cl_en) ? cl_res : eof_res;
      push.r0.last_of_run = (push.cnt == 2'd1);
      push.r1.last_of_run = 1'b1;
      if (!accept) push.cnt = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;     stage_ff <= STG_HDR_ID;
         id_ff    <= '0;        size_ff  <= '0;     left_ff <= '0;
         value_ff <= '0;        pleft_ff <= '0;     pos_ff  <= '0;
         level_ff <= '0;        leaf_ff  <= 1'b0;
         eoff_ff  <= '0;        elvl_ff  <= '0;
         soff_ff  <= '0;        ssize_ff <= '0;     sopen_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;  stage_ff <= stage_in;
         id_ff    <= id_in;     size_ff  <= size_in;  left_ff <= left_in;
         value_ff <= value_in;  pleft_ff <= pleft_in; pos_ff  <= pos_in;
         level_ff <= level_in;  leaf_ff  <= leaf_in;
         eoff_ff  <= eoff_in;   elvl_ff  <= elvl_in;
         soff_ff  <= soff_in;   ssize_ff <= ssize_in; sopen_ff <= sopen_in;
      end
   end

   // end positions: written on push only, read only below the stack level
   always_ff @(posedge clock) begin
      if (accept && push_en) end_ff[push_idx] <= push_val;
   end

   esp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .ready      (q_ready),
      .head_valid (q_valid),
      .head       (q_head)
   );

   assign rsp_valid          = q_valid;
   assign rsp_kind           = q_head.kind;
   assign rsp_element_id     = q_head.element_id;
   assign rsp_element_size   = q_head.element_size;
   assign rsp_payload_offset = q_head.payload_offset;
   assign rsp_leaf_value     = q_head.leaf_value;
   assign rsp_nest_level     = q_head.nest_level;
   assign rsp_last_of_run    = q_head.last_of_run;

endmodule

`default_nettype wire

[verif/ebml_element_stream_parser_core_tb.sv]
// Self-checking bench for ebml_element_stream_parser_core: random and directed files fed
// a byte at a time, results predicted per accepted word. Depends on esp_pkg and the core.
`timescale 1ns / 1ps

module ebml_element_stream_parser_core_tb;
   import esp_pkg::*;

   localparam int QUIET   = 300;      // no idling once this few bytes remain
   localparam int LIMIT   = 600000;   // cycle budget for the whole run
   localparam int N_BYTES = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_element_id;
   logic [55:0] rsp_element_size;
   logic [47:0] rsp_payload_offset;
   logic [63:0] rsp_leaf_value;
   logic [2:0]  rsp_nest_level;
   logic        rsp_last_of_run;

   ebml_element_stream_parser_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // pending bytes: {end_of_file, data}
   logic [8:0] byte_q[$];
   res_type    expected_words[$];
   int         mismatches = 0;
   int         cycles = 0;

   // ---------------------------------------------------------------
   // Parser shadow state
   // ---------------------------------------------------------------
   phase_type   ph;
   stage_type   stg;
   logic [31:0] id_acc;
   logic [55:0] size_acc;
   int          field_left;
   logic [63:0] value_acc;
   logic [55:0] pay_left;
   logic [47:0] pos;
   logic [47:0] end_pos[6];
   int          depth;
   logic        cur_leaf;
   logic [47:0] cur_off;
   int          cur_depth;
   logic [47:0] seg_off;
   logic [55:0] seg_size;
   logic        seg_open;
   int          n_new;

   function automatic void clear_parser();
      ph = PH_ID; stg = STG_HDR_ID;
      id_acc = '0; size_acc = '0; field_left = 0; value_acc = '0;
      pay_left = '0; pos = '0; depth = 0;
      foreach (end_pos[i]) end_pos[i] = '0;
      cur_leaf = 1'b0; cur_off = '0; cur_depth = 0;
      seg_off = '0; seg_size = '0; seg_open = 1'b0;
   endfunction

   function automatic void add_word(logic [1:0] k, logic [31:0] id, logic [55:0] sz,
                                    logic [47:0] off, logic [63:0] val, int lv);
      res_type r;
      if (n_new >= 2) return;
      r.kind = k; r.element_id = id; r.element_size = sz;
      r.payload_offset = off; r.leaf_value = val; r.nest_level = 3'(lv);
      r.last_of_run = 1'b0;
      expected_words.insert(expected_words.size(), r);
      n_new++;
   endfunction

   // pop masters from the top while their end is reached; popping the Segment finishes the file
   function automatic void pop_closed();
      int top;
      ph = PH_ID;
      while (depth > 0) begin
         top = depth - 1;
         if (top == 0 && seg_open) break;
         if (pos < end_pos[top]) break;
         depth = top;
         if (top == 0) begin
            add_word(KIND_SEGMENT, ID_SEGMENT, seg_size, seg_off, '0, 0);
            ph = PH_DONE;
            break;
         end
      end
   endfunction

   function automatic void open_payload(logic leaf);
      cur_leaf = leaf;
      value_acc = '0;
      if (size_acc == 0) begin
         if (leaf) add_word(KIND_LEAF, id_acc, '0, cur_off, '0, cur_depth);
         pop_closed();
      end else begin
         pay_left = size_acc;
         ph = PH_PAYLOAD;
      end
   endfunction

   function automatic void header_complete();
      logic [55:0] sum;
      logic        mst;
      mst = 1'b0;
      foreach (MASTER_IDS[i]) if (MASTER_IDS[i] == id_acc) mst = 1'b1;
      cur_off = pos;
      cur_depth = depth;
      sum = 56'(pos) + size_acc;
      if (stg == STG_HDR_BODY) begin
         stg = STG_SEARCH;
         open_payload(1'b0);
      end else if (depth == 0) begin
         if (id_acc == ID_SEGMENT) begin
            seg_off = pos; seg_size = size_acc; seg_open = (size_acc == 0);
            end_pos[0] = sum[47:0];
            depth = 1;
            pop_closed();
         end else begin
            open_payload(1'b0);
         end
      end else if (mst && depth < 6) begin
         // empty master opens nothing
         if (size_acc != 0) begin
            end_pos[depth] = sum[47:0];
            depth++;
         end
         pop_closed();
      end else begin
         open_payload(1'b1);
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic eof);
      n_new = 0;
      pos = pos + 48'd1;
      case (ph)
         PH_ID: begin
            if (field_left == 0) begin
               id_acc = {24'd0, b};
               if (b[7]) field_left = 0;
               else if (b[6]) field_left = 1;
               else if (b[5]) field_left = 2;
               else if (b[4]) field_left = 3;
               else id_acc = '0;   // bad first ID byte ends the ID as 0
            end else begin
               id_acc = {id_acc[23:0], b};
               field_left--;
            end
            if (field_left == 0) begin
               if (stg == STG_HDR_ID && id_acc != ID_EBML) begin
                  add_word(KIND_NOT_EBML, id_acc, '0, '0, '0, 0);
                  ph = PH_DONE;
               end else begin
                  if (stg == STG_HDR_ID) stg = STG_HDR_BODY;
                  ph = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            if (field_left == 0) begin
               size_acc = '0;   // a zero first byte is a one-byte size of 0
               for (int l = 1; l <= 8; l++) begin
                  if (b[8-l]) begin
                     field_left = l - 1;
                     size_acc = 56'(b & (8'hFF >> l));
                     break;
                  end
               end
            end else begin
               size_acc = {size_acc[47:0], b};
               field_left--;
            end
            if (field_left == 0) header_complete();
         end
         PH_PAYLOAD: begin
            if (cur_leaf && size_acc <= 8) value_acc = {value_acc[55:0], b};
            pay_left--;
            if (pay_left == 0) begin
               if (cur_leaf)
                  add_word(KIND_LEAF, id_acc, size_acc, cur_off,
                           size_acc <= 8 ? value_acc : 64'd0, cur_depth);
               pop_closed();
            end
         end
         default: ;
      endcase
      if (eof) begin
         if (ph != PH_DONE) begin
            if (stg == STG_HDR_ID) add_word(KIND_NOT_EBML, '0, '0, '0, '0, 0);
            else if (depth > 0) add_word(KIND_SEGMENT, ID_SEGMENT, seg_size, seg_off, '0, 0);
            else add_word(KIND_NO_SEG, '0, '0, '0, '0, 0);
         end
         clear_parser();
      end
      if (n_new > 0) expected_words[expected_words.size()-1].last_of_run = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // File builders
   // ---------------------------------------------------------------
   logic [7:0] fbuf[$];

   function automatic void put_byte(logic [7:0] v);
      fbuf.insert(fbuf.size(), v);
   endfunction

   function automatic void put_id(logic [31:0] id);
      if (id[31:24] != 0) put_byte(id[31:24]);
      if (id[31:16] != 0) put_byte(id[23:16]);
      if (id[31:8] != 0)  put_byte(id[15:8]);
      put_byte(id[7:0]);
   endfunction

   // size as a vint of len bytes
   function automatic void put_size(logic [63:0] v, int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = 8'(v >> (8 * (len - 1 - i)));
         if (i == 0) b = (b & (8'hFF >> len)) | (8'h80 >> (len - 1));
         put_byte(b);
      end
   endfunction

   function automatic int vint_len(logic [63:0] v, logic stretch);
      int l;
      l = 1;
      while (l < 8 && v >= (64'd1 << (7 * l))) l++;
      if (stretch) l = $urandom_range(l, 8);
      return l;
   endfunction

   // master size fields are four bytes, written once the content is known
   function automatic void patch_size(int at);
      logic [27:0] n;
      n = 28'(fbuf.size() - at - 4);
      fbuf[at]   = {4'h1, n[27:24]};
      fbuf[at+1] = n[23:16];
      fbuf[at+2] = n[15:8];
      fbuf[at+3] = n[7:0];
   endfunction

   function automatic logic [31:0] rand_leaf_id();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 3))
         0: return {24'd0, 1'b1, r[6:0]};
         1: return {16'd0, 2'b01, r[13:0]};
         2: return {8'd0, 3'b001, r[20:0]};
         default: return {4'b0001, r[27:0]};
      endcase
   endfunction

   function automatic void put_leaf();
      int sz;
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
      put_id(rand_leaf_id());
      put_size(64'(sz), vint_len(64'(sz), $urandom_range(0, 3) == 0));
      repeat (sz) put_byte(8'($urandom));
   endfunction

   function automatic void put_raw(logic [31:0] id, int sz);
      put_id(id);
      put_size(64'(sz), vint_len(64'(sz), $urandom_range(0, 1)));
      repeat (sz) put_byte(8'($urandom));
   endfunction

   function automatic void build_wellformed();
      int open_at[8];
      int nopen, nel, seg_at;
      logic open_ended;
      put_raw(ID_EBML, $urandom_range(0, 4));
      repeat ($urandom_range(0, 2)) put_raw({16'd0, 2'b01, 14'($urandom)}, $urandom_range(0, 3));
      put_id(ID_SEGMENT);
      open_ended = ($urandom_range(0, 3) == 0);
      seg_at = fbuf.size();
      if (open_ended) put_byte(8'h80);
      else repeat (4) put_byte(8'h00);
      nopen = 0;
      nel = $urandom_range(1, 14);
      for (int i = 0; i < nel; i++) begin
         case ($urandom_range(0, 5))
            0, 1: if (nopen < 8) begin
               put_id(MASTER_IDS[$urandom_range(0, 7)]);
               open_at[nopen] = fbuf.size();
               repeat (4) put_byte(8'h00);
               nopen++;
            end
            2: if (nopen > 0) begin
               nopen--;
               patch_size(open_at[nopen]);
            end
            default: put_leaf();
         endcase
      end
      while (nopen > 0) begin
         nopen--;
         patch_size(open_at[nopen]);
      end
      if (!open_ended) begin
         patch_size(seg_at);
         repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
      end
   endfunction

   function automatic void flush_file();
      for (int i = 0; i < fbuf.size(); i++)
         byte_q.insert(byte_q.size(), {i == fbuf.size() - 1, fbuf[i]});
      fbuf.delete();
   endfunction

   function automatic void build_random_file();
      int r, cut;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 10)) put_byte(8'($urandom));
      end else begin
         build_wellformed();
         if (r < 16) begin
            // truncated file
            cut = $urandom_range(1, fbuf.size());
            while (fbuf.size() > cut) void'(fbuf.pop_back());
         end else if (r < 22) begin
            // corrupted byte
            fbuf[$urandom_range(0, fbuf.size() - 1)] = 8'($urandom);
         end
      end
      flush_file();
   endfunction

   function automatic void build_directed();
      // bad first ID byte
      fbuf = '{8'h05, 8'hFF};                                   flush_file();
      // header ID cut short by end of file
      fbuf = '{8'h1A, 8'h45};                                   flush_file();
      // first ID complete but wrong
      fbuf = '{8'h1A, 8'h45, 8'hDF, 8'hA4, 8'h00};              flush_file();
      // header, zero first size byte, top junk, no Segment
      fbuf = '{8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h00, 8'hEC, 8'h81, 8'h00};
      flush_file();
      // open-ended Segment: size-0 leaf, 8-byte all-ones leaf, partial leaf
      fbuf = '{8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h80, 8'h18, 8'h53, 8'h80, 8'h67,
               8'h80, 8'hE7, 8'h00, 8'hE7, 8'h88, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h9F, 8'h83, 8'h01};
      flush_file();
   endfunction

   // ---------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------
   int send_gap = 0;
   always @(posedge clock) begin
      logic took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            predict_byte(req_data_byte, req_end_of_file);
            void'(byte_q.pop_front());
         end
         if (!(req_valid && !took)) begin
            if (send_gap == 0 && byte_q.size() > QUIET && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 17);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               req_valid       <= 1'b1;
               req_data_byte   <= byte_q[0][7:0];
               req_end_of_file <= byte_q[0][8];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random stall bursts, compare each accepted result word
   // ---------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      res_type e;
      logic    bad;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: kind %0d id %h", rsp_kind, rsp_element_id);
            end else begin
               e = expected_words.pop_front();
               bad = (rsp_kind != e.kind) || (rsp_element_id != e.element_id) ||
                     (rsp_element_size != e.element_size) ||
                     (rsp_payload_offset != e.payload_offset) ||
                     (rsp_leaf_value != e.leaf_value) ||
                     (rsp_nest_level != e.nest_level) ||
                     (rsp_last_of_run != e.last_of_run);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch exp: kind %0d id %h size %h off %h val %h lvl %0d last %0d",
                              e.kind, e.element_id, e.element_size, e.payload_offset,
                              e.leaf_value, e.nest_level, e.last_of_run);
                     $display("         got: kind %0d id %h size %h off %h val %h lvl %0d last %0d",
                              rsp_kind, rsp_element_id, rsp_element_size, rsp_payload_offset,
                              rsp_leaf_value, rsp_nest_level, rsp_last_of_run);
                  end
               end
            end
         end
         if (stall_left == 0 && byte_q.size() > QUIET && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 17);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clear_parser();
      build_directed();
      while (byte_q.size() < N_BYTES) build_random_file();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (byte_q.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[ebml_element_stream_parser_core.f]
sv/esp_pkg.sv
sv/esp_rsp_queue.sv
sv/ebml_element_stream_parser_core.sv
verif/ebml_element_stream_parser_core_tb.sv
